// ----- src/lce_pkg.sv -----
// Types and codes shared by the local conductor exponent block.
`timescale 1ns / 1ps

package lce_pkg;

    // One input beat.
    typedef struct packed {
        logic [4:0] type_code;
        logic [7:0] sym_power;
    } t_lce_in;

    // One result beat.
    typedef struct packed {
        logic [8:0]  tame_exponent;
        logic [9:0]  wild_exponent;
        logic [10:0] total_exponent;
        logic        bad_type;
    } t_lce_out;

    // Group of a reduction type on the tame side.
    typedef enum logic [3:0] {
        G_NONE,
        G_MULT,
        G_PMULT,
        G_C2,
        G_C3,
        G_C4,
        G_C6,
        G_Q8,
        G_C3C4,
        G_SL2
    } t_tgrp;

    // How the wild part is formed from the fixed-group tame values.
    typedef enum logic [3:0] {
        W_ZERO,
        W_Q8_HALF,
        W_Q8_ONE,
        W_Q8_C4,
        W_C3_HALF,
        W_C3_3HALF,
        W_C3,
        W_C2,
        W_C2_TWICE,
        W_C4_TWICE,
        W_SL2_A,
        W_SL2_B,
        W_SL2_C,
        W_SL2_D
    } t_wkind;

    // Scale for a division by three of a value below 8192: (x * 2731) >> 13.
    localparam logic [11:0] DIV3_MUL   = 12'd2731;
    localparam int          DIV3_SHIFT = 13;
    // Scale for a division by three of an 8-bit value: (x * 171) >> 9.
    localparam logic [7:0]  DIV3_MUL_S = 8'd171;

endpackage

// ----- src/local_conductor_exponents.sv -----
// Pipelined local conductor exponents for one reduction type and symmetric power.
`timescale 1ns / 1ps

// An item is taken at every clock edge with start high; busy is always low and the
// receiver cannot stall. The result appears on o_result with o_valid high once the
// item has passed all register stages, one result per item, in order. The five
// register stages are: input and type decode, the quotient of the power by three,
// the tame values of the item's group and of the four fixed groups, the wild
// numerator with its constant-reciprocal multiply, and the output register.
module local_conductor_exponents #(
    parameter int POWER_MAX = 255
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  lce_pkg::t_lce_in  i_in,
    output logic              busy,
    output logic              o_valid,
    output lce_pkg::t_lce_out o_result
);
    import lce_pkg::*;

    localparam logic [11:0] PMAX = 12'(POWER_MAX);

    function automatic t_tgrp tame_group(input logic [4:0] t);
        t_tgrp g;
        begin
            unique case (t)
                5'd1:                                 g = G_MULT;
                5'd29, 5'd30, 5'd31:                  g = G_PMULT;
                5'd2, 5'd16, 5'd17:                   g = G_C2;
                5'd3, 5'd14, 5'd18:                   g = G_C3;
                5'd4, 5'd22, 5'd23:                   g = G_C4;
                5'd6, 5'd15, 5'd19, 5'd20, 5'd21:     g = G_C6;
                5'd8, 5'd9, 5'd10:                    g = G_Q8;
                5'd12, 5'd13:                         g = G_C3C4;
                5'd24, 5'd25, 5'd26, 5'd27:           g = G_SL2;
                default:                              g = G_NONE;
            endcase
            return g;
        end
    endfunction

    function automatic t_wkind wild_kind(input logic [4:0] t);
        t_wkind w;
        begin
            unique case (t)
                5'd8:                                 w = W_Q8_HALF;
                5'd9:                                 w = W_Q8_ONE;
                5'd10:                                w = W_Q8_C4;
                5'd12:                                w = W_C3_HALF;
                5'd13:                                w = W_C3_3HALF;
                5'd14, 5'd15, 5'd18, 5'd19:           w = W_C3;
                5'd16, 5'd20, 5'd30:                  w = W_C2;
                5'd17, 5'd21, 5'd29:                  w = W_C2_TWICE;
                5'd22, 5'd23:                         w = W_C4_TWICE;
                5'd24:                                w = W_SL2_A;
                5'd25:                                w = W_SL2_B;
                5'd26:                                w = W_SL2_C;
                5'd27:                                w = W_SL2_D;
                default:                              w = W_ZERO;
            endcase
            return w;
        end
    endfunction

    // Tame value for power m, with q = m / 3, r = m % 3, k = m / 12, r12 = m % 12.
    function automatic logic [8:0] tame_val(
        input t_tgrp      g,
        input logic [7:0] m,
        input logic [6:0] q,
        input logic [1:0] r,
        input logic [4:0] k,
        input logic [3:0] r12
    );
        logic [8:0] mp1;
        logic [8:0] c3v;
        logic [8:0] v;
        logic [8:0] off;
        begin
            mp1 = {1'b0, m} + 9'd1;
            if (r == 2'd0) begin
                c3v = {1'b0, q, 1'b0};
            end else if (r == 2'd1) begin
                c3v = mp1 - {2'b0, q};
            end else begin
                c3v = {1'b0, m} - {2'b0, q};
            end
            case (r12)
                4'd2:    off = 9'd3;
                4'd4:    off = 9'd4;
                4'd6:    off = 9'd6;
                4'd8:    off = 9'd7;
                4'd10:   off = 9'd10;
                default: off = 9'd0;
            endcase
            v = 9'd0;
            unique case (g)
                G_MULT:  v = {1'b0, m};
                G_PMULT: v = m[0] ? mp1 : {1'b0, m};
                G_C2:    v = m[0] ? mp1 : 9'd0;
                G_C3:    v = c3v;
                G_C6:    v = m[0] ? mp1 : c3v;
                G_C4: begin
                    if (m[0]) begin
                        v = mp1;
                    end else begin
                        v = {2'b0, m[7:1]} + {8'b0, m[1]};
                    end
                end
                G_Q8: begin
                    if (m[0]) begin
                        v = mp1;
                    end else begin
                        v = ({3'b0, m[7:2]} * 9'd3) + (m[1] ? 9'd3 : 9'd0);
                    end
                end
                G_C3C4: begin
                    if (m[0]) begin
                        v = mp1;
                    end else begin
                        v = ({4'b0, k} * 9'd10) + off;
                    end
                end
                G_SL2: begin
                    if (m[0]) begin
                        v = mp1;
                    end else begin
                        case (r12)
                            4'd2:    off = 9'd3;
                            4'd4:    off = 9'd5;
                            4'd6:    off = 9'd6;
                            4'd8:    off = 9'd8;
                            4'd10:   off = 9'd11;
                            default: off = 9'd0;
                        endcase
                        v = ({4'b0, k} * 9'd11) + off;
                    end
                end
                default: v = 9'd0;
            endcase
            return v;
        end
    endfunction

    // Stage 1: input register and type decode.
    logic       r_v1, n_v1;
    logic [7:0] r_m1, n_m1;
    t_tgrp      r_g1, n_g1;
    t_wkind     r_w1, n_w1;
    logic       r_kill1, n_kill1;
    logic       r_bad1, n_bad1;

    // Stage 2: quotient by three.
    logic       r_v2;
    logic [7:0] r_m2;
    logic [6:0] r_q2, n_q2;
    t_tgrp      r_g2;
    t_wkind     r_w2;
    logic       r_kill2, r_bad2;
    logic [15:0] n_prod2;

    // Stage 3: tame values.
    logic       r_v3;
    logic [8:0] r_tame3, n_tame3;
    logic [8:0] r_c2, r_c3, r_c4, r_c8;
    logic [8:0] n_c2, n_c3, n_c4, n_c8;
    t_wkind     r_w3;
    logic       r_kill3, r_bad3;
    logic [1:0] n_r3;
    logic [3:0] n_r12;
    logic [4:0] n_k;

    // Stage 4: wild numerator and reciprocal multiply.
    logic        r_v4;
    logic [8:0]  r_tame4;
    logic [9:0]  r_wdir4, n_wdir4;
    logic [23:0] r_wprod4, n_wprod4;
    logic        r_usediv4, n_usediv4;
    logic        r_kill4, r_bad4;
    logic [11:0] n_num;

    // Stage 5: output register.
    logic       r_v5;
    t_lce_out   r_res5, n_res5;
    logic [9:0] n_wild;

    assign busy = 1'b0;

    always_comb begin
        n_v1    = start;
        n_m1    = ({4'b0, i_in.sym_power} > PMAX) ? PMAX[7:0] : i_in.sym_power;
        n_g1    = tame_group(i_in.type_code);
        n_w1    = wild_kind(i_in.type_code);
        n_bad1  = (n_m1 != 8'd0) && (n_g1 == G_NONE);
        n_kill1 = (n_m1 == 8'd0) || n_bad1;
    end

    always_comb begin
        n_prod2 = {8'b0, r_m1} * {8'b0, DIV3_MUL_S};
        n_q2    = n_prod2[15:9];
    end

    always_comb begin
        n_r3  = 2'(r_m2 - ({r_q2, 1'b0} + {1'b0, r_q2}));
        n_r12 = ({2'b0, r_q2[1:0]} * 4'd3) + {2'b0, n_r3};
        n_k   = r_q2[6:2];
        n_tame3 = tame_val(r_g2, r_m2, r_q2, n_r3, n_k, n_r12);
        n_c2    = tame_val(G_C2, r_m2, r_q2, n_r3, n_k, n_r12);
        n_c3    = tame_val(G_C3, r_m2, r_q2, n_r3, n_k, n_r12);
        n_c4    = tame_val(G_C4, r_m2, r_q2, n_r3, n_k, n_r12);
        n_c8    = tame_val(G_Q8, r_m2, r_q2, n_r3, n_k, n_r12);
    end

    // Divisions by six go through a halving followed by the shared divide by three.
    always_comb begin
        n_wdir4   = 10'd0;
        n_num     = 12'd0;
        n_usediv4 = 1'b0;
        unique case (r_w3)
            W_Q8_HALF:  n_wdir4 = {1'b0, r_c8} + {2'b0, r_c2[8:1]};
            W_Q8_ONE:   n_wdir4 = {1'b0, r_c8} + {1'b0, r_c2};
            W_Q8_C4:    n_wdir4 = {1'b0, r_c8} + {1'b0, r_c4} + {1'b0, r_c2};
            W_C3_HALF:  n_wdir4 = {2'b0, r_c3[8:1]};
            W_C3_3HALF: n_wdir4 = 10'(({2'b0, r_c3} * 11'd3) >> 1);
            W_C3:       n_wdir4 = {1'b0, r_c3};
            W_C2:       n_wdir4 = {1'b0, r_c2};
            W_C2_TWICE: n_wdir4 = {r_c2, 1'b0};
            W_C4_TWICE: n_wdir4 = {r_c4, 1'b0} + {1'b0, r_c2};
            W_SL2_A: begin
                n_num     = 12'(({3'b0, r_c8} * 12'd2 + {3'b0, r_c2}) >> 1);
                n_usediv4 = 1'b1;
            end
            W_SL2_B: begin
                n_num     = {3'b0, r_c8} + ({3'b0, r_c2} * 12'd2);
                n_usediv4 = 1'b1;
            end
            W_SL2_C: begin
                n_num     = {3'b0, r_c8} + ({3'b0, r_c2} * 12'd5);
                n_usediv4 = 1'b1;
            end
            W_SL2_D: begin
                n_num     = 12'(({3'b0, r_c8} * 12'd10 + {3'b0, r_c2} * 12'd5) >> 1);
                n_usediv4 = 1'b1;
            end
            default: n_wdir4 = 10'd0;
        endcase
        n_wprod4 = {12'b0, n_num} * {12'b0, DIV3_MUL};
    end

    always_comb begin
        n_wild = r_usediv4 ? r_wprod4[DIV3_SHIFT +: 10] : r_wdir4;
        if (r_kill4) begin
            n_res5.tame_exponent  = 9'd0;
            n_res5.wild_exponent  = 10'd0;
            n_res5.total_exponent = 11'd0;
        end else begin
            n_res5.tame_exponent  = r_tame4;
            n_res5.wild_exponent  = n_wild;
            n_res5.total_exponent = {2'b0, r_tame4} + {1'b0, n_wild};
        end
        n_res5.bad_type = r_bad4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1      <= n_m1;
        r_g1      <= n_g1;
        r_w1      <= n_w1;
        r_kill1   <= n_kill1;
        r_bad1    <= n_bad1;

        r_m2      <= r_m1;
        r_q2      <= n_q2;
        r_g2      <= r_g1;
        r_w2      <= r_w1;
        r_kill2   <= r_kill1;
        r_bad2    <= r_bad1;

        r_tame3   <= n_tame3;
        r_c2      <= n_c2;
        r_c3      <= n_c3;
        r_c4      <= n_c4;
        r_c8      <= n_c8;
        r_w3      <= r_w2;
        r_kill3   <= r_kill2;
        r_bad3    <= r_bad2;

        r_tame4   <= r_tame3;
        r_wdir4   <= n_wdir4;
        r_wprod4  <= n_wprod4;
        r_usediv4 <= n_usediv4;
        r_kill4   <= r_kill3;
        r_bad4    <= r_bad3;

        r_res5    <= n_res5;
    end

    assign o_valid  = r_v5;
    assign o_result = r_res5;

endmodule

// ----- tb/sv/lce_checker.sv -----
// Checker for the local conductor exponent block: predicts each result and compares it.
`timescale 1ns / 1ps

module lce_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  lce_pkg::t_lce_in  i_cmd,
    input  logic              i_valid,
    input  lce_pkg::t_lce_out i_result,
    output int                o_fails,
    output int                o_pending,
    output int                o_checked
);
    import lce_pkg::*;

    t_lce_out exponents_due[$];

    function automatic t_tgrp group_of(input logic [4:0] t);
        case (t)
            5'd1:                               return G_MULT;
            5'd29, 5'd30, 5'd31:                return G_PMULT;
            5'd2, 5'd16, 5'd17:                 return G_C2;
            5'd3, 5'd14, 5'd18:                 return G_C3;
            5'd4, 5'd22, 5'd23:                 return G_C4;
            5'd6, 5'd15, 5'd19, 5'd20, 5'd21:   return G_C6;
            5'd8, 5'd9, 5'd10:                  return G_Q8;
            5'd12, 5'd13:                       return G_C3C4;
            5'd24, 5'd25, 5'd26, 5'd27:         return G_SL2;
            default:                            return G_NONE;
        endcase
    endfunction

    function automatic t_wkind wild_kind_of(input logic [4:0] t);
        case (t)
            5'd8:                               return W_Q8_HALF;
            5'd9:                               return W_Q8_ONE;
            5'd10:                              return W_Q8_C4;
            5'd12:                              return W_C3_HALF;
            5'd13:                              return W_C3_3HALF;
            5'd14, 5'd15, 5'd18, 5'd19:         return W_C3;
            5'd16, 5'd20, 5'd30:                return W_C2;
            5'd17, 5'd21, 5'd29:                return W_C2_TWICE;
            5'd22, 5'd23:                       return W_C4_TWICE;
            5'd24:                              return W_SL2_A;
            5'd25:                              return W_SL2_B;
            5'd26:                              return W_SL2_C;
            5'd27:                              return W_SL2_D;
            default:                            return W_ZERO;
        endcase
    endfunction

    // Tame value of a group for a power m of at least one.
    function automatic int unsigned group_tame(input t_tgrp g, input int unsigned m);
        int unsigned r6;
        int unsigned r12;
        r6 = m % 6;
        r12 = m % 12;
        case (g)
            G_MULT:  return m;
            G_PMULT: return m[0] ? m + 1 : m;
            G_C2:    return m[0] ? m + 1 : 0;
            G_C3: begin
                if (m % 3 == 0) return (2 * m) / 3;
                if (m % 3 == 1) return m + 1 - (m - 1) / 3;
                return m + 1 - (m + 1) / 3;
            end
            G_C4: begin
                if (m[0]) return m + 1;
                if (m % 4 == 0) return m / 2;
                return 1 + m / 2;
            end
            G_C6: begin
                if (r6[0]) return m + 1;
                if (r6 == 0) return (2 * m) / 3;
                if (r6 == 4) return m + 1 - (m - 1) / 3;
                return m + 1 - (m + 1) / 3;
            end
            G_Q8: begin
                if (m[0]) return m + 1;
                if (m % 4 == 0) return (3 * m) / 4;
                return (3 * m + 6) / 4;
            end
            G_C3C4: begin
                if (r12[0]) return m + 1;
                case (r12)
                    0:       return (5 * m) / 6;
                    2:       return (5 * m + 8) / 6;
                    4:       return (5 * m + 4) / 6;
                    6:       return (5 * m) / 6 + 1;
                    8:       return (5 * m + 2) / 6;
                    default: return (5 * m + 10) / 6;
                endcase
            end
            G_SL2: begin
                if (r12[0]) return m + 1;
                case (r12)
                    0:       return (11 * m) / 12;
                    2:       return (11 * m + 14) / 12;
                    4:       return (11 * m + 16) / 12;
                    6:       return (11 * m + 6) / 12;
                    8:       return (11 * m + 8) / 12;
                    default: return (11 * m + 22) / 12;
                endcase
            end
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned wild_value(input t_wkind k, input int unsigned m);
        int unsigned c2;
        int unsigned c3;
        int unsigned c4;
        int unsigned c8;
        c2 = group_tame(G_C2, m);
        c3 = group_tame(G_C3, m);
        c4 = group_tame(G_C4, m);
        c8 = group_tame(G_Q8, m);
        case (k)
            W_Q8_HALF:  return c8 + c2 / 2;
            W_Q8_ONE:   return c8 + c2;
            W_Q8_C4:    return c8 + c4 + c2;
            W_C3_HALF:  return c3 / 2;
            W_C3_3HALF: return (3 * c3) / 2;
            W_C3:       return c3;
            W_C2:       return c2;
            W_C2_TWICE: return 2 * c2;
            W_C4_TWICE: return 2 * c4 + c2;
            W_SL2_A:    return (2 * c8 + c2) / 6;
            W_SL2_B:    return (c8 + 2 * c2) / 3;
            W_SL2_C:    return (c8 + 5 * c2) / 3;
            W_SL2_D:    return (10 * c8 + 5 * c2) / 6;
            default:    return 0;
        endcase
    endfunction

    function automatic t_lce_out predict_exponents(input t_lce_in cmd);
        t_lce_out    res;
        t_tgrp       grp;
        int unsigned m;
        int unsigned tame;
        int unsigned wild;
        m = cmd.sym_power;
        grp = group_of(cmd.type_code);
        tame = 0;
        wild = 0;
        res = '0;
        // A zero power gives all zeros and no error, even for a bad type.
        if (m != 0) begin
            if (grp == G_NONE) begin
                res.bad_type = 1'b1;
            end else begin
                tame = group_tame(grp, m);
                wild = wild_value(wild_kind_of(cmd.type_code), m);
            end
        end
        res.tame_exponent  = tame[8:0];
        res.wild_exponent  = wild[9:0];
        res.total_exponent = 11'(tame + wild);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_lce_out got;
        t_lce_out want;
        if (!i_rst_n) begin
            exponents_due.delete();
            o_fails   <= 0;
            o_checked <= 0;
        end else begin
            if (i_start && !i_busy) begin
                exponents_due.push_back(predict_exponents(i_cmd));
            end
            if (i_valid) begin
                got = i_result;
                if (exponents_due.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, got);
                    o_fails <= o_fails + 1;
                end else begin
                    want = exponents_due.pop_front();
                    o_checked <= o_checked + 1;
                    if (got !== want) begin
                        $display("%0t: mismatch tame exp %0d got %0d, wild exp %0d got %0d",
                                 $time, want.tame_exponent, got.tame_exponent,
                                 want.wild_exponent, got.wild_exponent);
                        $display("%0t:          total exp %0d got %0d, bad_type exp %0b got %0b",
                                 $time, want.total_exponent, got.total_exponent,
                                 want.bad_type, got.bad_type);
                        o_fails <= o_fails + 1;
                    end
                end
            end
        end
    end

    assign o_pending = exponents_due.size();

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the local conductor exponent testbench: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;
    import lce_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int N_RANDOM     = 900;
    localparam int N_DIRECTED   = 25;
    localparam int DRAIN_CYCLES = 10;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    t_lce_in  i_in;
    logic     busy;
    logic     o_valid;
    t_lce_out o_result;

    int fails;
    int pending;
    int checked;
    int sent;
    int quiet_cycles = 0;

    local_conductor_exponents dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_in     (i_in),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    lce_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_cmd     (i_in),
        .i_valid   (o_valid),
        .i_result  (o_result),
        .o_fails   (fails),
        .o_pending (pending),
        .o_checked (checked)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Ends the run if neither a command nor a result moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
            $display("[local_conductor_exponents] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // When may_idle is set, holds start low for a random number of cycles, then presents one beat until taken.
    task automatic send_command(input logic [4:0] t, input logic [7:0] m, input bit may_idle);
        t_lce_in cmd;
        cmd.type_code = t;
        cmd.sym_power = m;
        while (may_idle && $urandom_range(0, 99) < 21) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= cmd;
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    logic [4:0] dir_type  [N_DIRECTED] = '{
        5'd31, 5'd0,  5'd5,  5'd0,  5'd5,  5'd7,  5'd11, 5'd28, 5'd1,  5'd29,
        5'd2,  5'd17, 5'd3,  5'd14, 5'd4,  5'd22, 5'd6,  5'd19, 5'd8,  5'd10,
        5'd12, 5'd13, 5'd24, 5'd26, 5'd27
    };
    logic [7:0] dir_power [N_DIRECTED] = '{
        8'd0,   8'd0,   8'd0,   8'd1,   8'd7,   8'd255, 8'd3,   8'd200, 8'd255, 8'd255,
        8'd255, 8'd2,   8'd255, 8'd4,   8'd255, 8'd6,   8'd254, 8'd10,  8'd255, 8'd6,
        8'd254, 8'd22,  8'd255, 8'd14,  8'd246
    };

    initial begin
        logic [4:0] t;
        logic [7:0] m;
        int         pick;
        sent         = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_in         = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_command(dir_type[i], dir_power[i], 1'b0);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            t = 5'($urandom_range(0, 31));
            pick = $urandom_range(0, 9);
            // Small powers walk every residue class; zero and the top value come often.
            if (pick == 0) m = 8'd0;
            else if (pick == 1) m = 8'd255;
            else if (pick <= 4) m = 8'($urandom_range(1, 24));
            else m = 8'($urandom_range(0, 255));
            send_command(t, m, !(i >= 400 && i < 600));
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d commands over all type codes, powers 0 to 255 and both extremes,",
                 sent);
        $display("with random gaps and a back-to-back stretch; %0d results compared.", checked);
        if (fails == 0 && pending == 0) begin
            $display("[local_conductor_exponents] OK");
        end else begin
            $display("[local_conductor_exponents] ERROR");
        end
        $finish;
    end

endmodule

// ----- local_conductor_exponents.f -----
src/lce_pkg.sv
src/local_conductor_exponents.sv
tb/sv/lce_checker.sv
tb/sv/tb_top.sv
